>>> rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg - shared types and constants of the message stream deframer
// Result record, result kinds, queue status and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    // Header bytes: type, id low, id high, length low, length high
    localparam int unsigned HEADER_BYTES = 5;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BORROW_CODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENQUEUE_CODE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAIL_CODE    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_CODE   = 8'd3;

    // Register reset values
    localparam logic [7:0] BORROW_CODE_RST  = 8'd0;
    localparam logic [7:0] ENQUEUE_CODE_RST = 8'd1;
    localparam logic [7:0] FAIL_CODE_RST    = 8'd2;
    localparam logic [7:0] EXTRA_CODE_RST   = 8'd255;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_BORROW  = 3'd2,
        KIND_FAIL    = 3'd3,
        KIND_BADTYPE = 3'd4,
        KIND_SHORT   = 3'd5
    } kind_t;

    // One result record
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  message_type;
        logic [15:0] message_id;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_length;
        logic [7:0]  buffer_length;
        logic [15:0] offending_id;
        logic [7:0]  error_code;
        logic        message_end;
        logic        cut_off;
    } result_t;

    // Queue status seen by the back and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage : msd_pkg

`default_nettype wire

>>> rtl/msd_front.sv
// ----------------------------------------------------------------------------
// msd_front - byte parser of the message stream deframer
// Holds the type code registers, walks each header and payload one byte
// per cycle while byte_accept is high and builds at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_front
    import msd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // accepted byte
    input  wire logic                   byte_accept,
    input  wire logic [7:0]             stream_byte,
    input  wire logic                   buffer_end,
    // result toward the queue
    output logic                        push,
    output result_t                     push_data
);

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PH_TYPE    = 6'b000001,
        PH_ID_LO   = 6'b000010,
        PH_ID_HI   = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_LEN_HI  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        CAT_BORROW  = 3'd0,
        CAT_ENQUEUE = 3'd1,
        CAT_FAIL    = 3'd2,
        CAT_SKIP    = 3'd3,
        CAT_UNKNOWN = 3'd4
    } cat_t;

    logic [7:0]  borrow_code_reg, enqueue_code_reg, fail_code_reg, extra_code_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] scratch_reg, scratch_next;

    cat_t        cat;
    logic [15:0] pos_inc;
    logic [15:0] need;
    logic        have;
    result_t     rec;

    // Write type code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            borrow_code_reg  <= BORROW_CODE_RST;
            enqueue_code_reg <= ENQUEUE_CODE_RST;
            fail_code_reg    <= FAIL_CODE_RST;
            extra_code_reg   <= EXTRA_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BORROW_CODE:  borrow_code_reg  <= cfg_data;
                REG_ENQUEUE_CODE: enqueue_code_reg <= cfg_data;
                REG_FAIL_CODE:    fail_code_reg    <= cfg_data;
                REG_EXTRA_CODE:   extra_code_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the held type, borrow first, then enqueue, fail, extra
    always_comb
    begin
        if (type_reg == borrow_code_reg)
            cat = CAT_BORROW;
        else if (type_reg == enqueue_code_reg)
            cat = CAT_ENQUEUE;
        else if (type_reg == fail_code_reg)
            cat = CAT_FAIL;
        else if (type_reg == extra_code_reg)
            cat = CAT_SKIP;
        else
            cat = CAT_UNKNOWN;
    end

    assign pos_inc = pos_reg + 16'd1;

    // Advance the parser and build the result of this byte
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        type_next    = type_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        scratch_next = scratch_reg;
        have         = 1'b0;
        need         = 16'd0;
        rec          = '0;
        rec.kind     = KIND_HEADER;

        case (phase_reg)
            PH_TYPE:
            begin
                type_next    = stream_byte;
                id_next      = 16'd0;
                len_next     = 16'd0;
                pos_next     = 16'd0;
                scratch_next = 16'd0;
                phase_next   = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                id_next    = {8'd0, stream_byte};
                phase_next = PH_ID_HI;
            end
            PH_ID_HI:
            begin
                id_next    = {stream_byte, id_reg[7:0]};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = {8'd0, stream_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next = {stream_byte, len_reg[7:0]};
                if (cat == CAT_BORROW)
                    need = 16'd2;
                else if (cat == CAT_FAIL)
                    need = 16'd3;
                if (cat == CAT_UNKNOWN)
                    rec.kind = KIND_BADTYPE;
                else if (len_next < need)
                    rec.kind = KIND_SHORT;
                else
                    rec.kind = KIND_HEADER;
                have     = 1'b1;
                pos_next = 16'd0;
                if (len_next == 16'd0)
                begin
                    rec.message_end = 1'b1;
                    phase_next      = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                pos_next = pos_inc;
                case (cat)
                    CAT_ENQUEUE:
                    begin
                        rec.kind         = KIND_PAYLOAD;
                        rec.payload_byte = stream_byte;
                        have             = 1'b1;
                    end
                    CAT_BORROW:
                    begin
                        if (pos_reg == 16'd0)
                            scratch_next = {8'd0, stream_byte};
                        else if (pos_reg == 16'd1)
                        begin
                            rec.kind          = KIND_BORROW;
                            rec.frame_length  = scratch_reg[7:0];
                            rec.buffer_length = stream_byte;
                            have              = 1'b1;
                        end
                    end
                    CAT_FAIL:
                    begin
                        if (pos_reg == 16'd0)
                            scratch_next = {8'd0, stream_byte};
                        else if (pos_reg == 16'd1)
                            scratch_next = {stream_byte, scratch_reg[7:0]};
                        else if (pos_reg == 16'd2)
                        begin
                            rec.kind         = KIND_FAIL;
                            rec.offending_id = scratch_reg;
                            rec.error_code   = stream_byte;
                            have             = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (pos_inc >= len_reg)
                begin
                    rec.message_end = have;
                    phase_next      = PH_TYPE;
                end
            end
            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase

        // Flag a message cut off by the end of the buffer
        if (buffer_end)
        begin
            if (phase_next != PH_TYPE)
            begin
                rec.cut_off = 1'b1;
                if (!have)
                begin
                    rec.kind = KIND_SHORT;
                    have     = 1'b1;
                end
            end
            phase_next = PH_TYPE;
        end

        rec.message_type   = type_next;
        rec.message_id     = id_next;
        rec.payload_length = len_next;
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            pos_reg     <= 16'd0;
            type_reg    <= 8'd0;
            id_reg      <= 16'd0;
            len_reg     <= 16'd0;
            scratch_reg <= 16'd0;
        end
        else if (byte_accept)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            type_reg    <= type_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            scratch_reg <= scratch_next;
        end
    end

    assign push      = byte_accept && have;
    assign push_data = rec;

endmodule : msd_front

`default_nettype wire

>>> rtl/msd_queue.sv
// ----------------------------------------------------------------------------
// msd_queue - result queue between parser and output stage
// Small first-in first-out buffer of result records in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_queue
    import msd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire result_t  push_data,
    input  wire logic     pop,
    output result_t       head,
    output q_status_t     status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    result_t       entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    // Store request data at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule : msd_queue

`default_nettype wire

>>> rtl/msd_back.sv
// ----------------------------------------------------------------------------
// msd_back - output stage of the message stream deframer
// Pulls result records from the queue into the output register and
// holds them until the downstream side takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_back
    import msd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire result_t   head,
    input  wire q_status_t status,
    output logic           pop,
    input  wire logic      out_stall,
    output logic           out_valid,
    output result_t        out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    // Refill the output register when it is empty or being taken
    assign load       = !valid_reg || !out_stall;
    assign pop        = load && !status.empty;
    assign valid_next = load ? !status.empty : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the record while stalled
    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule : msd_back

`default_nettype wire

>>> rtl/message_stream_deframer.sv
// ----------------------------------------------------------------------------
// message_stream_deframer - top level
// Splits a byte stream of back-to-back messages into header, payload,
// borrow, fail and error results.
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  ----------------------------------
//   input    in         in_valid / in_stall  stream_byte, buffer_end
//   output   out        out_valid/out_stall  kind ... cut_off (one result)
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; each byte gives zero or one result.
// The parser is combinational: the edge that takes a byte writes its result
// into the queue, and a later edge moves it into the output register once
// that register is empty or being taken, which raises out_valid.
// in_stall rises only when the result queue is full, so an output stall
// reaches the input after QUEUE_DEPTH + 1 results pile up.
// Reset clears the parser to the type byte and loads the default codes.
// ----------------------------------------------------------------------------
`default_nettype none

module message_stream_deframer
    import msd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // byte input
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             stream_byte,
    input  wire logic                   buffer_end,
    // result output
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [2:0]                  kind,
    output logic [7:0]                  message_type,
    output logic [15:0]                 message_id,
    output logic [15:0]                 payload_length,
    output logic [7:0]                  payload_byte,
    output logic [7:0]                  frame_length,
    output logic [7:0]                  buffer_length,
    output logic [15:0]                 offending_id,
    output logic [7:0]                  error_code,
    output logic                        message_end,
    output logic                        cut_off,
    // configuration
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic      byte_accept;
    logic      push;
    logic      pop;
    result_t   push_data;
    result_t   head;
    result_t   out_data;
    q_status_t status;

    assign cfg_ready   = 1'b1;
    assign in_stall    = status.full;
    assign byte_accept = in_valid && !in_stall;

    // Parse bytes
    msd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_accept (byte_accept),
        .stream_byte (stream_byte),
        .buffer_end  (buffer_end),
        .push        (push),
        .push_data   (push_data)
    );

    // Buffer results
    msd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (status)
    );

    // Drive results out
    msd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (status),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign message_type   = out_data.message_type;
    assign message_id     = out_data.message_id;
    assign payload_length = out_data.payload_length;
    assign payload_byte   = out_data.payload_byte;
    assign frame_length   = out_data.frame_length;
    assign buffer_length  = out_data.buffer_length;
    assign offending_id   = out_data.offending_id;
    assign error_code     = out_data.error_code;
    assign message_end    = out_data.message_end;
    assign cut_off        = out_data.cut_off;

    // Never write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("result queue written while full");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("result queue read while empty");

    // A cut-off message cannot also be complete
    a_cut_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cut_off |-> !message_end)
        else $error("result marks both cut off and message end");

    // Only defined result kinds leave the block
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_HEADER || kind == KIND_PAYLOAD ||
                       kind == KIND_BORROW || kind == KIND_FAIL ||
                       kind == KIND_BADTYPE || kind == KIND_SHORT))
        else $error("undefined result kind");

endmodule : message_stream_deframer

`default_nettype wire

>>> test/message_stream_deframer_tb.sv
// ----------------------------------------------------------------------------
// message_stream_deframer_tb - self-checking testbench of the deframer
// Feeds byte buffers of well-formed, cut-off and noisy messages under several
// type code settings. Idling and stalls are random, with one long output hold.
// Every result is checked field by field against an in-bench deframer model.
// ----------------------------------------------------------------------------

module message_stream_deframer_tb;

    import msd_pkg::*;

    // Parser phases of the in-bench model, one-hot
    typedef enum logic [5:0] {
        PH_TYPE    = 6'b000001,
        PH_ID_LO   = 6'b000010,
        PH_ID_HI   = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_LEN_HI  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } parse_phase_t;

    // Message classes after type code matching
    typedef enum logic [2:0] {
        CLS_BORROW,
        CLS_ENQUEUE,
        CLS_FAIL,
        CLS_EXTRA,
        CLS_UNKNOWN
    } msg_class_t;

    // Index outside the register map; a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hC4;

    localparam int unsigned SETTLE_CYCLES = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             stream_byte;
    logic                   buffer_end;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             kind;
    logic [7:0]             message_type;
    logic [15:0]            message_id;
    logic [15:0]            payload_length;
    logic [7:0]             payload_byte;
    logic [7:0]             frame_length;
    logic [7:0]             buffer_length;
    logic [15:0]            offending_id;
    logic [7:0]             error_code;
    logic                   message_end;
    logic                   cut_off;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Type codes as the block should hold them
    logic [7:0]   borrow_code;
    logic [7:0]   enqueue_code;
    logic [7:0]   fail_code;
    logic [7:0]   extra_code;

    // Parser state of the model
    parse_phase_t phase_q;
    logic [15:0]  pay_pos;
    logic [7:0]   held_type;
    logic [15:0]  held_id;
    logic [15:0]  held_len;
    logic [15:0]  scratch;

    result_t      pending_results[$];
    result_t      want_r;
    bit           failed;
    bit           quiet;
    int           hold_cycles;
    int           bytes_sent;

    message_stream_deframer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .buffer_end     (buffer_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .message_type   (message_type),
        .message_id     (message_id),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .frame_length   (frame_length),
        .buffer_length  (buffer_length),
        .offending_id   (offending_id),
        .error_code     (error_code),
        .message_end    (message_end),
        .cut_off        (cut_off),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Match a type byte against the codes, borrow first, extra last
    function automatic msg_class_t classify_type(input logic [7:0] t);
        begin
            if (t == borrow_code) return CLS_BORROW;
            if (t == enqueue_code) return CLS_ENQUEUE;
            if (t == fail_code) return CLS_FAIL;
            if (t == extra_code) return CLS_EXTRA;
            return CLS_UNKNOWN;
        end
    endfunction

    // Advance the model by one byte; return 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [7:0] b, input logic is_last,
                                        output result_t r);
        msg_class_t  cls;
        bit          have;
        logic [15:0] idx;
        int          need;
        begin
            r    = '0;
            have = 1'b0;
            case (phase_q)
                PH_TYPE:
                begin
                    held_type = b;
                    held_id   = '0;
                    held_len  = '0;
                    pay_pos   = '0;
                    scratch   = '0;
                    phase_q   = PH_ID_LO;
                end
                PH_ID_LO:
                begin
                    held_id = {8'h00, b};
                    phase_q = PH_ID_HI;
                end
                PH_ID_HI:
                begin
                    held_id[15:8] = b;
                    phase_q       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    held_len = {8'h00, b};
                    phase_q  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    held_len[15:8] = b;
                    cls  = classify_type(held_type);
                    need = (cls == CLS_BORROW) ? 2 : (cls == CLS_FAIL) ? 3 : 0;
                    if (cls == CLS_UNKNOWN)
                        r.kind = KIND_BADTYPE;
                    else if (held_len < need)
                        r.kind = KIND_SHORT;
                    else
                        r.kind = KIND_HEADER;
                    have    = 1'b1;
                    pay_pos = '0;
                    if (held_len == 16'd0)
                    begin
                        r.message_end = 1'b1;
                        phase_q       = PH_TYPE;
                    end
                    else
                    begin
                        phase_q = PH_PAYLOAD;
                    end
                end
                default:
                begin
                    idx     = pay_pos;
                    pay_pos = pay_pos + 16'd1;
                    cls     = classify_type(held_type);
                    if (cls == CLS_ENQUEUE)
                    begin
                        r.kind         = KIND_PAYLOAD;
                        r.payload_byte = b;
                        have           = 1'b1;
                    end
                    else if (cls == CLS_BORROW)
                    begin
                        if (idx == 16'd0)
                            scratch = {8'h00, b};
                        else if (idx == 16'd1)
                        begin
                            r.kind          = KIND_BORROW;
                            r.frame_length  = scratch[7:0];
                            r.buffer_length = b;
                            have            = 1'b1;
                        end
                    end
                    else if (cls == CLS_FAIL)
                    begin
                        if (idx == 16'd0)
                            scratch = {8'h00, b};
                        else if (idx == 16'd1)
                            scratch[15:8] = b;
                        else if (idx == 16'd2)
                        begin
                            r.kind         = KIND_FAIL;
                            r.offending_id = scratch;
                            r.error_code   = b;
                            have           = 1'b1;
                        end
                    end
                    if (pay_pos >= held_len)
                    begin
                        if (have) r.message_end = 1'b1;
                        phase_q = PH_TYPE;
                    end
                end
            endcase

            // Buffer end inside a message: flag it, report short if silent
            if (is_last)
            begin
                if (phase_q != PH_TYPE)
                begin
                    r.cut_off = 1'b1;
                    if (!have)
                    begin
                        r.kind = KIND_SHORT;
                        have   = 1'b1;
                    end
                end
                phase_q = PH_TYPE;
            end

            r.message_type   = held_type;
            r.message_id     = held_id;
            r.payload_length = held_len;
            return have;
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        begin
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failed = 1'b1;
            end
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result kind %0d with no request waiting", kind);
                failed = 1'b1;
            end
            else
            begin
                want_r = pending_results.pop_front();
                check_field("kind", 16'(want_r.kind), 16'(kind));
                check_field("message_type", 16'(want_r.message_type),
                            16'(message_type));
                check_field("message_id", want_r.message_id, message_id);
                check_field("payload_length", want_r.payload_length, payload_length);
                check_field("payload_byte", 16'(want_r.payload_byte),
                            16'(payload_byte));
                check_field("frame_length", 16'(want_r.frame_length),
                            16'(frame_length));
                check_field("buffer_length", 16'(want_r.buffer_length),
                            16'(buffer_length));
                check_field("offending_id", want_r.offending_id, offending_id);
                check_field("error_code", 16'(want_r.error_code), 16'(error_code));
                check_field("message_end", 16'(want_r.message_end),
                            16'(message_end));
                check_field("cut_off", 16'(want_r.cut_off), 16'(cut_off));
            end
        end
    end

    // Drive output stall: long holds on request, else random bursts
    initial
    begin : receiver
        int burst_left;
        bit stalling;
        out_stall  = 1'b0;
        burst_left = 0;
        stalling   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall   <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    stalling   = ($urandom_range(0, 2) == 0);
                    burst_left = stalling ? $urandom_range(1, 7) : $urandom_range(1, 12);
                end
                burst_left = burst_left - 1;
                out_stall  <= stalling && !quiet;
            end
        end
    end

    // Offer one byte, hold it until taken, then predict its result
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        result_t r;
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            @(negedge clk);
            in_valid    <= 1'b1;
            stream_byte <= b;
            buffer_end  <= is_last;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            if (deframe_byte(b, is_last, r)) pending_results.push_back(r);
            bytes_sent++;
        end
    endtask

    // Send one message; cut_at >= 0 ends the buffer at that byte instead
    task automatic send_message(input logic [7:0] mtype, input logic [15:0] id,
                                input logic [15:0] len, input int cut_at,
                                input bit end_buffer);
        int         total;
        logic [7:0] b;
        begin
            total = (cut_at >= 0) ? cut_at + 1 : 5 + int'(len);
            for (int i = 0; i < total; i++)
            begin
                case (i)
                    0:       b = mtype;
                    1:       b = id[7:0];
                    2:       b = id[15:8];
                    3:       b = len[7:0];
                    4:       b = len[15:8];
                    default: b = 8'($urandom);
                endcase
                send_byte(b, (i == total - 1) && (cut_at >= 0 || end_buffer));
            end
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (idx)
                REG_BORROW_CODE:  borrow_code  = data;
                REG_ENQUEUE_CODE: enqueue_code = data;
                REG_FAIL_CODE:    fail_code    = data;
                REG_EXTRA_CODE:   extra_code   = data;
                default: ;
            endcase
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Drop input, drain all results, let the pipeline settle
    task automatic wait_idle;
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_codes(input logic [7:0] b, input logic [7:0] e,
                             input logic [7:0] f, input logic [7:0] x);
        begin
            wait_idle();
            write_register(REG_BORROW_CODE, b);
            write_register(REG_ENQUEUE_CODE, e);
            write_register(REG_FAIL_CODE, f);
            write_register(REG_EXTRA_CODE, x);
        end
    endtask

    // Mostly well-formed messages; some cut off, some with huge lengths
    task automatic random_message;
        int          pick;
        int          cut;
        logic [7:0]  mtype;
        logic [15:0] len;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 24)
                mtype = borrow_code;
            else if (pick < 50)
                mtype = enqueue_code;
            else if (pick < 72)
                mtype = fail_code;
            else if (pick < 80)
                mtype = extra_code;
            else
                mtype = 8'($urandom);
            cut = -1;
            if ($urandom_range(0, 9) == 0)
            begin
                len = 16'($urandom);
                cut = $urandom_range(0, 12);
                if (cut >= 5 + int'(len)) cut = -1;
            end
            else
            begin
                len = 16'($urandom_range(0, 6));
                if ($urandom_range(0, 7) == 0) cut = $urandom_range(0, 4 + int'(len));
            end
            send_message(mtype, 16'($urandom), len, cut, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic random_traffic(input int target);
        int start;
        int n;
        begin
            start = bytes_sent;
            while (bytes_sent - start < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise burst closed by a buffer end
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
                end
                else
                begin
                    random_message();
                end
            end
        end
    endtask

    // Default codes: fail, short borrow, bad type, cut-off header and payload
    task automatic test_directed_cases;
        begin
            send_message(fail_code, 16'hFFFF, 16'd3, -1, 1'b1);
            send_message(borrow_code, 16'h0000, 16'd1, -1, 1'b0);
            send_message(8'h80, 16'h00FF, 16'd0, -1, 1'b0);
            send_message(enqueue_code, 16'hFF00, 16'hFFFF, 5, 1'b0);
            send_message(extra_code, 16'hA5A5, 16'd0, 0, 1'b0);
        end
    endtask

    task automatic test_extreme_codes;
        begin
            set_codes(8'hFF, 8'h00, 8'h80, 8'h7F);
            random_traffic(150);
        end
    endtask

    // Overlapping codes exercise the match priority; stray index is ignored
    task automatic test_code_priority;
        begin
            set_codes(8'h33, 8'h44, 8'h44, 8'h33);
            write_register(REG_UNMAPPED, 8'h5A);
            random_traffic(150);
        end
    endtask

    task automatic test_random_codes;
        begin
            for (int p = 0; p < 4; p++)
            begin
                set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                random_traffic(120);
            end
        end
    endtask

    // Hold the output long enough for the queue to fill and stall the input
    task automatic test_output_backpressure;
        begin
            set_codes(BORROW_CODE_RST, ENQUEUE_CODE_RST, FAIL_CODE_RST, EXTRA_CODE_RST);
            quiet       = 1'b1;
            hold_cycles = 80;
            send_message(enqueue_code, 16'h1234, 16'd40, -1, 1'b1);
            quiet       = 1'b0;
        end
    endtask

    task automatic test_steady_stream;
        begin
            quiet = 1'b1;
            random_traffic(150);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        stream_byte  = '0;
        buffer_end   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        failed       = 1'b0;
        quiet        = 1'b0;
        hold_cycles  = 0;
        bytes_sent   = 0;
        borrow_code  = BORROW_CODE_RST;
        enqueue_code = ENQUEUE_CODE_RST;
        fail_code    = FAIL_CODE_RST;
        extra_code   = EXTRA_CODE_RST;
        phase_q      = PH_TYPE;
        pay_pos      = '0;
        held_type    = '0;
        held_id      = '0;
        held_len     = '0;
        scratch      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_extreme_codes();
        test_code_priority();
        test_random_codes();
        test_output_backpressure();
        test_steady_stream();

        wait_idle();
        if (!failed && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
